// ===== rtl/abs_pkg.sv =====
// Shared types and constants for the Armijo backtracking step-size controller.
package abs_pkg;

	// Widths of the fixed-point formats.
	localparam int MERIT_W = 32;   // Q16.16 signed
	localparam int ALPHA_W = 24;   // Q8.16 unsigned
	localparam int COEF_W  = 16;   // Q0.16 unsigned
	localparam int COUNT_W = 8;
	localparam int CA_W    = ALPHA_W + COEF_W;  // c*alpha, Q8.32
	localparam int ACC_W   = 76;   // exact Q.48 test value plus margin
	localparam int CA_LO_W = 24;   // low slice of c*alpha fed to the multiplier
	localparam int PROD_W  = CA_LO_W + 1 + MERIT_W;

	// Configuration register indexes.
	localparam logic [2:0] REG_SEARCH_MODE = 3'd0;
	localparam logic [2:0] REG_INIT_STEP   = 3'd1;
	localparam logic [2:0] REG_SHRINK      = 3'd2;
	localparam logic [2:0] REG_DECREASE    = 3'd3;
	localparam logic [2:0] REG_LIMIT       = 3'd4;

	// Result kinds.
	localparam logic [1:0] RK_TRIAL = 2'd0;
	localparam logic [1:0] RK_DONE  = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [ALPHA_W-1:0] INIT_STEP_RST = 24'd65536;
	localparam logic [COEF_W-1:0]  SHRINK_RST    = 16'd32768;
	localparam logic [COEF_W-1:0]  DECREASE_RST  = 16'd6554;
	localparam logic [COUNT_W-1:0] LIMIT_RST     = 8'd30;

	// Operation pending in the controller.
	typedef enum logic [1:0] {
		OP_START,
		OP_ERROR,
		OP_REPORT
	} op_t;

	typedef struct packed {
		logic                search_mode;
		logic [ALPHA_W-1:0]  initial_step;
		logic [COEF_W-1:0]   shrink_factor;
		logic [COEF_W-1:0]   decrease_coefficient;
		logic [COUNT_W-1:0]  backtrack_limit;
	} cfg_t;

	typedef struct packed {
		logic start_load;   // latch reference values and first alpha
		logic report_load;  // latch trial merit, update best, form c*alpha
		logic mac_lo;       // accumulate low slice product
		logic mac_hi;       // accumulate high slice product
		logic emit;         // write the output register
		op_t  kind;         // which result to form on emit
	} cmd_t;

	typedef struct packed {
		logic start_bad;    // directional mode with non-negative slope
		logic rule_met;     // sufficient decrease holds
		logic limit_hit;    // no more backtracks allowed
	} status_t;

endpackage

// ===== rtl/armijo_backtracking_search.sv =====
// Top level of the Armijo backtracking step-size controller: configuration and wiring.
// A start item goes straight to the finish step, where its result is registered; for a report item
// the controller first walks c*alpha through one 25x32 multiplier in two slices.
// One item is in work at a time, so a new item is taken only after the last one has finished
// and its result is registered; a full output register holds the finish step and the input.
// Asynchronous active-low reset idles the search, empties the output and resets configuration.
module armijo_backtracking_search
	import abs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic signed [MERIT_W-1:0] start_merit,
	input  logic signed [MERIT_W-1:0] start_slope,
	input  logic signed [MERIT_W-1:0] trial_merit,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                result_kind,
	output logic [ALPHA_W-1:0]        step_alpha,
	output logic signed [MERIT_W-1:0] step_merit,
	output logic [COUNT_W-1:0]        backtrack_count,
	output logic                      accepted,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [ALPHA_W-1:0]        cfg_data
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	// Configuration writes are always taken; indexes past the last register are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.search_mode          <= 1'b0;
			cfg_q.initial_step         <= INIT_STEP_RST;
			cfg_q.shrink_factor        <= SHRINK_RST;
			cfg_q.decrease_coefficient <= DECREASE_RST;
			cfg_q.backtrack_limit      <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SEARCH_MODE: cfg_q.search_mode          <= cfg_data[0];
				REG_INIT_STEP:   cfg_q.initial_step         <= cfg_data;
				REG_SHRINK:      cfg_q.shrink_factor        <= cfg_data[COEF_W-1:0];
				REG_DECREASE:    cfg_q.decrease_coefficient <= cfg_data[COEF_W-1:0];
				REG_LIMIT:       cfg_q.backtrack_limit      <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// The controller sequences each item and owns the search and output-valid flags.
	abs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds alpha, the best point so far and the exact decrease test,
	// and writes the result payload registers.
	abs_datapath u_dp (
		.clk             (clk),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.status          (status),
		.start_merit     (start_merit),
		.start_slope     (start_slope),
		.trial_merit     (trial_merit),
		.result_kind     (result_kind),
		.step_alpha      (step_alpha),
		.step_merit      (step_merit),
		.backtrack_count (backtrack_count),
		.accepted        (accepted)
	);

endmodule

// ===== rtl/abs_ctrl.sv =====
// Controller state machine of the Armijo backtracking step-size controller.
module abs_ctrl
	import abs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    func,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC_LO,
		ST_MAC_HI,
		ST_FINISH
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   busy_q;
	logic   out_valid_q;
	logic   in_acc;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.kind        = op_q;
		cmd.start_load  = in_acc && !func && !status.start_bad;
		cmd.report_load = in_acc && func && busy_q;
		cmd.mac_lo      = (state_q == ST_MAC_LO);
		cmd.mac_hi      = (state_q == ST_MAC_HI);
		cmd.emit        = (state_q == ST_FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ERROR;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!func) begin
							if (status.start_bad) begin
								op_q   <= OP_ERROR;
								busy_q <= 1'b0;
							end else begin
								op_q   <= OP_START;
								busy_q <= 1'b1;
							end
							state_q <= ST_FINISH;
						end else if (busy_q) begin
							op_q    <= OP_REPORT;
							state_q <= ST_MAC_LO;
						end else begin
							op_q    <= OP_ERROR;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_MAC_LO: state_q <= ST_MAC_HI;
				ST_MAC_HI: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (slot_free) begin
						if (op_q == OP_REPORT && (status.rule_met || status.limit_hit)) begin
							busy_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A report during a search always walks both accumulate steps before finishing.
	a_report_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && func && busy_q) |=>
			(state_q == ST_MAC_LO) ##1 (state_q == ST_MAC_HI) ##1 (state_q == ST_FINISH))
		else $error("report item did not follow the accumulate sequence");

	// A result only appears out of the finish state.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result raised outside the finish state");

	// Only an accepted start item opens a search.
	a_busy_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(in_acc && !func))
		else $error("search opened without a start item");

endmodule

// ===== rtl/abs_datapath.sv =====
// Datapath of the Armijo backtracking step-size controller: alpha, best tracking, rule test.
module abs_datapath
	import abs_pkg::*;
(
	input  logic                      clk,
	input  cfg_t                      cfg,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic signed [MERIT_W-1:0] start_merit,
	input  logic signed [MERIT_W-1:0] start_slope,
	input  logic signed [MERIT_W-1:0] trial_merit,
	output logic [1:0]                result_kind,
	output logic [ALPHA_W-1:0]        step_alpha,
	output logic signed [MERIT_W-1:0] step_merit,
	output logic [COUNT_W-1:0]        backtrack_count,
	output logic                      accepted
);

	logic signed [MERIT_W-1:0] ref_q, slope_q, merit_q, best_merit_q;
	logic [ALPHA_W-1:0]        alpha_q, best_alpha_q;
	logic [COUNT_W-1:0]        steps_q;
	logic [CA_W-1:0]           ca_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic [COEF_W-1:0]         umul_b;
	logic [CA_W-1:0]           umul;
	logic [ALPHA_W-1:0]        shrunk, next_alpha, first_alpha;
	logic signed [MERIT_W:0]   diff;
	logic signed [MERIT_W-1:0] mac_y;
	logic [CA_LO_W-1:0]        mac_part;
	logic signed [PROD_W-1:0]  mac_prod;
	logic signed [ACC_W-1:0]   mac_ext, mac_term;
	logic                      best_upd;

	// One 24x16 multiplier: c*alpha on a report, alpha*shrink when finishing.
	assign umul_b = cmd.report_load ? cfg.decrease_coefficient : cfg.shrink_factor;
	assign umul   = CA_W'(alpha_q) * CA_W'(umul_b);
	assign shrunk = umul[CA_W-1:COEF_W];
	assign next_alpha  = (shrunk == '0) ? ALPHA_W'(1) : shrunk;
	assign first_alpha = (cfg.initial_step == '0) ? ALPHA_W'(1) : cfg.initial_step;

	// Test value: (m - ref)*2^32 + c*alpha*ref (relative) or - c*alpha*slope (directional).
	assign diff     = {trial_merit[MERIT_W-1], trial_merit} - {ref_q[MERIT_W-1], ref_q};
	assign mac_y    = cfg.search_mode ? slope_q : ref_q;
	assign mac_part = cmd.mac_hi ? CA_LO_W'(ca_q[CA_W-1:CA_LO_W]) : ca_q[CA_LO_W-1:0];
	assign mac_prod = $signed({1'b0, mac_part}) * mac_y;
	assign mac_ext  = {{(ACC_W-PROD_W){mac_prod[PROD_W-1]}}, mac_prod};
	assign mac_term = cmd.mac_hi ? (mac_ext <<< CA_LO_W) : mac_ext;

	assign best_upd = (steps_q == '0) || (trial_merit < best_merit_q);

	assign status.start_bad = cfg.search_mode && !start_slope[MERIT_W-1];
	assign status.rule_met  = acc_q[ACC_W-1] || (acc_q == '0);
	assign status.limit_hit = (steps_q >= cfg.backtrack_limit);

	always_ff @(posedge clk) begin
		if (cmd.start_load) begin
			ref_q        <= start_merit;
			slope_q      <= start_slope;
			alpha_q      <= first_alpha;
			best_alpha_q <= first_alpha;
			best_merit_q <= '0;
			steps_q      <= '0;
		end
		if (cmd.report_load) begin
			merit_q <= trial_merit;
			ca_q    <= umul;
			acc_q   <= {{(ACC_W-MERIT_W-33){diff[MERIT_W]}}, diff, 32'd0};
			if (best_upd) begin
				best_merit_q <= trial_merit;
				best_alpha_q <= alpha_q;
			end
		end
		if (cmd.mac_lo || cmd.mac_hi) begin
			acc_q <= cfg.search_mode ? (acc_q - mac_term) : (acc_q + mac_term);
		end
		if (cmd.emit) begin
			unique case (cmd.kind)
				OP_START: begin
					result_kind     <= RK_TRIAL;
					step_alpha      <= alpha_q;
					step_merit      <= '0;
					backtrack_count <= '0;
					accepted        <= 1'b0;
				end
				OP_REPORT: begin
					if (status.rule_met) begin
						result_kind     <= RK_DONE;
						step_alpha      <= alpha_q;
						step_merit      <= merit_q;
						backtrack_count <= steps_q;
						accepted        <= 1'b1;
					end else if (status.limit_hit) begin
						result_kind     <= RK_DONE;
						step_alpha      <= best_alpha_q;
						step_merit      <= best_merit_q;
						backtrack_count <= steps_q;
						accepted        <= 1'b0;
					end else begin
						result_kind     <= RK_TRIAL;
						step_alpha      <= next_alpha;
						step_merit      <= '0;
						backtrack_count <= steps_q + COUNT_W'(1);
						accepted        <= 1'b0;
						alpha_q         <= next_alpha;
						steps_q         <= steps_q + COUNT_W'(1);
					end
				end
				default: begin
					result_kind     <= RK_ERROR;
					step_alpha      <= '0;
					step_merit      <= '0;
					backtrack_count <= '0;
					accepted        <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/abs_tb_pkg.sv =====
// Codes shared by the step-size controller testbench modules.
package abs_tb_pkg;

	// Encoding of the func field of an input item.
	localparam logic FUNC_START  = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	// Encoding of the search_mode register.
	localparam logic MODE_RELATIVE    = 1'b0;
	localparam logic MODE_DIRECTIONAL = 1'b1;

	// A register index that maps to no register.
	localparam logic [2:0] REG_UNUSED = 3'd7;

endpackage

// ===== tb/sv/armijo_backtracking_search_checker.sv =====
// Checker that mirrors the step-size controller and compares every result item.
module armijo_backtracking_search_checker
	import abs_pkg::*;
	import abs_tb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      func,
	input  logic signed [MERIT_W-1:0] start_merit,
	input  logic signed [MERIT_W-1:0] start_slope,
	input  logic signed [MERIT_W-1:0] trial_merit,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [1:0]                result_kind,
	input  logic [ALPHA_W-1:0]        step_alpha,
	input  logic signed [MERIT_W-1:0] step_merit,
	input  logic [COUNT_W-1:0]        backtrack_count,
	input  logic                      accepted,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [ALPHA_W-1:0]        cfg_data,
	output int                        fail_count,
	output int                        awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	// Wide enough for the exact Q.48 comparison of either rule.
	typedef logic signed [95:0] wide_t;

	typedef struct {
		logic [1:0]                kind;
		logic [ALPHA_W-1:0]        alpha;
		logic signed [MERIT_W-1:0] merit;
		logic [COUNT_W-1:0]        count;
		logic                      acc;
	} step_reply_t;

	localparam wide_t UNIT_Q32 = 96'sd4294967296;

	cfg_t                      regs;
	logic                      searching;
	logic [ALPHA_W-1:0]        trial_alpha;
	logic [ALPHA_W-1:0]        best_alpha;
	logic signed [MERIT_W-1:0] best_merit;
	logic signed [MERIT_W-1:0] ref_merit;
	logic signed [MERIT_W-1:0] ref_slope;
	logic [COUNT_W-1:0]        shrinks;
	step_reply_t               replies_due[$];
	int                        errors;
	int                        results_seen;

	function automatic step_reply_t reply(input logic [1:0] k, input logic [ALPHA_W-1:0] a,
			input logic signed [MERIT_W-1:0] m, input logic [COUNT_W-1:0] n, input logic ok);
		step_reply_t r;
		r.kind  = k;
		r.alpha = a;
		r.merit = m;
		r.count = n;
		r.acc   = ok;
		return r;
	endfunction

	// Sufficient decrease test at the current alpha, both sides scaled to Q.48.
	function automatic logic armijo_holds(input logic signed [MERIT_W-1:0] m);
		wide_t ca, lhs, rhs, mw, rw, sw;
		ca  = regs.decrease_coefficient * trial_alpha;
		mw  = m;
		rw  = ref_merit;
		sw  = ref_slope;
		lhs = mw <<< 32;
		if (regs.search_mode == MODE_DIRECTIONAL)
			rhs = (rw <<< 32) + ca * sw;
		else
			rhs = (UNIT_Q32 - ca) * rw;
		return lhs <= rhs;
	endfunction

	task automatic advance_search(input logic f, input logic signed [MERIT_W-1:0] sm,
			input logic signed [MERIT_W-1:0] ss, input logic signed [MERIT_W-1:0] tm,
			output step_reply_t r);
		logic [ALPHA_W+COEF_W-1:0] scaled;
		if (f == FUNC_START) begin
			if (regs.search_mode == MODE_DIRECTIONAL && ss >= 0) begin
				searching = 1'b0;
				r = reply(RK_ERROR, '0, '0, '0, 1'b0);
			end else begin
				searching   = 1'b1;
				ref_merit   = sm;
				ref_slope   = ss;
				trial_alpha = (regs.initial_step != '0) ? regs.initial_step : ALPHA_W'(1);
				best_alpha  = trial_alpha;
				best_merit  = '0;
				shrinks     = '0;
				r = reply(RK_TRIAL, trial_alpha, '0, '0, 1'b0);
			end
		end else if (!searching) begin
			r = reply(RK_ERROR, '0, '0, '0, 1'b0);
		end else begin
			if (shrinks == '0 || tm < best_merit) begin
				best_merit = tm;
				best_alpha = trial_alpha;
			end
			if (armijo_holds(tm)) begin
				searching = 1'b0;
				r = reply(RK_DONE, trial_alpha, tm, shrinks, 1'b1);
			end else if (shrinks >= regs.backtrack_limit) begin
				searching = 1'b0;
				r = reply(RK_DONE, best_alpha, best_merit, shrinks, 1'b0);
			end else begin
				scaled      = trial_alpha * regs.shrink_factor;
				trial_alpha = scaled[ALPHA_W+COEF_W-1:COEF_W];
				if (trial_alpha == '0)
					trial_alpha = ALPHA_W'(1);
				shrinks++;
				r = reply(RK_TRIAL, trial_alpha, '0, shrinks, 1'b0);
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t: result %0d: %s", $realtime, results_seen, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_reply_t want, fresh;
		if (!arst_n) begin
			regs = '{search_mode: MODE_RELATIVE, initial_step: INIT_STEP_RST,
				shrink_factor: SHRINK_RST, decrease_coefficient: DECREASE_RST,
				backtrack_limit: LIMIT_RST};
			searching    = 1'b0;
			trial_alpha  = '0;
			best_alpha   = '0;
			best_merit   = '0;
			ref_merit    = '0;
			ref_slope    = '0;
			shrinks      = '0;
			errors       = 0;
			results_seen = 0;
			replies_due.delete();
			fail_count <= 0;
			awaiting   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					want = replies_due.pop_front();
					if (result_kind !== want.kind)
						report_mismatch($sformatf("result_kind %0d, expected %0d",
							result_kind, want.kind));
					if (step_alpha !== want.alpha)
						report_mismatch($sformatf("step_alpha %h, expected %h",
							step_alpha, want.alpha));
					if (step_merit !== want.merit)
						report_mismatch($sformatf("step_merit %h, expected %h",
							step_merit, want.merit));
					if (backtrack_count !== want.count)
						report_mismatch($sformatf("backtrack_count %0d, expected %0d",
							backtrack_count, want.count));
					if (accepted !== want.acc)
						report_mismatch($sformatf("accepted %b, expected %b",
							accepted, want.acc));
				end
				results_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SEARCH_MODE: regs.search_mode          = cfg_data[0];
					REG_INIT_STEP:   regs.initial_step         = cfg_data;
					REG_SHRINK:      regs.shrink_factor        = cfg_data[COEF_W-1:0];
					REG_DECREASE:    regs.decrease_coefficient = cfg_data[COEF_W-1:0];
					REG_LIMIT:       regs.backtrack_limit      = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				advance_search(func, start_merit, start_slope, trial_merit, fresh);
				replies_due.push_back(fresh);
			end
			fail_count <= errors;
			awaiting   <= replies_due.size();
		end
	end

endmodule

// ===== tb/sv/armijo_backtracking_search_test.sv =====
// Top of the step-size controller testbench: clock, reset, stimulus, idling and verdict.
module armijo_backtracking_search_test
	import abs_pkg::*;
	import abs_tb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// After the last result, a quiet settle time leaves room for anything still in flight.
	localparam int SETTLE_CYCLES   = 8;
	// The long receiver hold-off must stay well under the watchdog limit.
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 140;
	// One search is driven through every allowed shrink of the largest limit.
	localparam int EXHAUST_REPORTS = 260;

	localparam logic signed [MERIT_W-1:0] MERIT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [MERIT_W-1:0] MERIT_MIN = 32'sh8000_0000;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      func;
	logic signed [MERIT_W-1:0] start_merit;
	logic signed [MERIT_W-1:0] start_slope;
	logic signed [MERIT_W-1:0] trial_merit;
	logic                      out_valid;
	logic                      out_ready;
	logic [1:0]                result_kind;
	logic [ALPHA_W-1:0]        step_alpha;
	logic signed [MERIT_W-1:0] step_merit;
	logic [COUNT_W-1:0]        backtrack_count;
	logic                      accepted;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [2:0]                cfg_index;
	logic [ALPHA_W-1:0]        cfg_data;
	int                        fail_count;
	int                        awaiting;

	// Knobs shared between the stimulus and the receiver. The odds are the chance,
	// in percent, that an idle burst starts before an item or on a given cycle.
	int   tx_odds;
	int   rx_odds;
	bit   hold_off;
	int   items_sent;
	logic mode_now;
	int   limit_now;

	armijo_backtracking_search DUT (.*);

	armijo_backtracking_search_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one item. The valid stays high across back-to-back items; it only drops
	// when an idle burst is inserted in front of the next one.
	task automatic offer_item(input logic f, input logic signed [MERIT_W-1:0] sm,
			input logic signed [MERIT_W-1:0] ss, input logic signed [MERIT_W-1:0] tm);
		int gap;
		if ($urandom_range(0, 99) < tx_odds) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		start_merit <= sm;
		start_slope <= ss;
		trial_merit <= tm;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Drop the input valid, wait until every expected result has come back, then give
	// the block its settle time before anything is reconfigured.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller lowers cfg_valid after its last write.
	task automatic write_reg(input logic [2:0] idx, input logic [ALPHA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic mode, input logic [ALPHA_W-1:0] step,
			input logic [COEF_W-1:0] shrink, input logic [COEF_W-1:0] decrease,
			input logic [COUNT_W-1:0] limit);
		settle();
		write_reg(REG_SEARCH_MODE, ALPHA_W'(mode));
		write_reg(REG_INIT_STEP, step);
		write_reg(REG_SHRINK, ALPHA_W'(shrink));
		write_reg(REG_DECREASE, ALPHA_W'(decrease));
		write_reg(REG_LIMIT, ALPHA_W'(limit));
		cfg_valid <= 1'b0;
		mode_now  = mode;
		limit_now = limit;
	endtask

	// Reference merits: mostly random with a random magnitude, sometimes the extremes.
	function automatic logic signed [MERIT_W-1:0] pick_ref();
		logic signed [MERIT_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = MERIT_MAX;
			1: v = MERIT_MIN;
			default: begin
				v = $urandom;
				v = v >>> $urandom_range(0, 24);
			end
		endcase
		return v;
	endfunction

	// Slopes of random magnitude. In directional mode they are nearly always negative,
	// since a non-negative slope there only produces an error.
	function automatic logic signed [MERIT_W-1:0] pick_slope();
		logic signed [MERIT_W-1:0] s;
		s = $urandom;
		s = s >>> $urandom_range(0, 31);
		if (mode_now == MODE_DIRECTIONAL && s >= 0 && $urandom_range(0, 19) != 0)
			s = ~s;
		return s;
	endfunction

	// Trial merits cluster around the reference so that both outcomes of the
	// sufficient decrease test come up often.
	function automatic logic signed [MERIT_W-1:0] pick_merit(input logic signed [MERIT_W-1:0] r);
		logic signed [MERIT_W-1:0] d, v;
		d = $urandom;
		d = d >>> $urandom_range(0, 31);
		case ($urandom_range(0, 9))
			0:       v = MERIT_MAX;
			1:       v = MERIT_MIN;
			2:       v = $urandom;
			3, 4:    v = r - (r >>> $urandom_range(1, 6));
			5:       v = r;
			default: v = r + d;
		endcase
		return v;
	endfunction

	// A well-formed search: a start followed by a run of reports. The run may be
	// longer than the search, so the tail can land on an idle block.
	task automatic random_search();
		logic signed [MERIT_W-1:0] r;
		int n;
		r = pick_ref();
		n = $urandom_range(1, (limit_now < 10) ? limit_now + 2 : 12);
		offer_item(FUNC_START, r, pick_slope(), $urandom);
		repeat (n) offer_item(FUNC_REPORT, $urandom, $urandom, pick_merit(r));
	endtask

	// Broken sequences and noise: lone reports, starts with a non-negative slope and
	// items with every field random.
	task automatic stray_item();
		logic signed [MERIT_W-1:0] s;
		case ($urandom_range(0, 2))
			0: offer_item(FUNC_REPORT, $urandom, $urandom, $urandom);
			1: begin
				s = $urandom;
				s[MERIT_W-1] = 1'b0;
				offer_item(FUNC_START, pick_ref(), s, $urandom);
			end
			default: offer_item(logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
		endcase
	endtask

	// Every report lies above the reference and the slope is negative, so the rule
	// never holds and the search runs out of backtracks.
	task automatic exhaust_search();
		logic signed [MERIT_W-1:0] r;
		r = 32'sd100 <<< 16;
		offer_item(FUNC_START, r, -32'sd7, $urandom);
		repeat (EXHAUST_REPORTS)
			offer_item(FUNC_REPORT, $urandom, $urandom, r + $urandom_range(1, 1 << 20));
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request so that the
	// output register stays full and the block has to refuse new items.
	initial begin
		int n;
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if ($urandom_range(0, 99) < rx_odds) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: a run in which no channel moves for too long has hung.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("armijo_backtracking_search_test NOT OK");
		$finish;
	end

	initial begin
		int phase, goal;
		bit pressed;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		func        <= FUNC_START;
		start_merit <= '0;
		start_slope <= '0;
		trial_merit <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_SEARCH_MODE;
		cfg_data    <= '0;
		tx_odds     = 30;
		rx_odds     = 20;
		items_sent  = 0;
		pressed     = 1'b0;
		mode_now    = MODE_RELATIVE;
		limit_now   = LIMIT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset configuration: relative rule, alpha starts at 1.0.
		// A report before any start is an error.
		offer_item(FUNC_REPORT, MERIT_MAX, MERIT_MIN, MERIT_MAX);
		// Largest reference; the most negative merit passes at once.
		offer_item(FUNC_START, MERIT_MAX, MERIT_MAX, '0);
		offer_item(FUNC_REPORT, '0, '0, MERIT_MIN);
		// Most negative reference; the largest merit fails and alpha shrinks.
		offer_item(FUNC_START, MERIT_MIN, MERIT_MIN, '0);
		offer_item(FUNC_REPORT, '0, '0, MERIT_MAX);
		// A start in the middle of a search drops it; zero reference passes with zero.
		offer_item(FUNC_START, '0, -32'sd1, MERIT_MAX);
		offer_item(FUNC_REPORT, MERIT_MAX, MERIT_MAX, '0);
		offer_item(FUNC_REPORT, '0, '0, '0);

		// Directional rule with every coefficient at its top value and two backtracks.
		program_regs(MODE_DIRECTIONAL, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd2);
		// A zero slope and a positive slope are both refused, and the block stays idle.
		offer_item(FUNC_START, 32'sd1 <<< 16, '0, '0);
		offer_item(FUNC_START, 32'sd1 <<< 16, MERIT_MAX, '0);
		offer_item(FUNC_REPORT, '0, '0, '0);
		// Fail until the limit: the finish returns the best merit, not accepted.
		offer_item(FUNC_START, 32'sd100 <<< 16, MERIT_MIN, '0);
		offer_item(FUNC_REPORT, '0, '0, MERIT_MAX);
		offer_item(FUNC_REPORT, '0, '0, 32'sd100 <<< 16);
		offer_item(FUNC_REPORT, '0, '0, 32'sd100 <<< 16);

		// A write to an index with no register behind it must change nothing.
		settle();
		write_reg(REG_UNUSED, '1);
		cfg_valid <= 1'b0;
		// Zero step, zero shrink and zero coefficient: alpha sits at one LSB and the
		// rule becomes merit <= reference.
		program_regs(MODE_RELATIVE, '0, '0, '0, 8'd3);
		offer_item(FUNC_START, -(32'sd5 <<< 16), MERIT_MIN, '0);
		offer_item(FUNC_REPORT, '0, '0, -(32'sd5 <<< 16) + 32'sd1);
		offer_item(FUNC_REPORT, '0, '0, -(32'sd5 <<< 16));

		// The mode changes while a search is open: the start passes the slope check
		// under the directional rule, the reports are judged by the relative rule.
		settle();
		write_reg(REG_SEARCH_MODE, ALPHA_W'(MODE_DIRECTIONAL));
		cfg_valid <= 1'b0;
		mode_now = MODE_DIRECTIONAL;
		offer_item(FUNC_START, 32'sd1000, -32'sd1, '0);
		settle();
		write_reg(REG_SEARCH_MODE, ALPHA_W'(MODE_RELATIVE));
		cfg_valid <= 1'b0;
		mode_now = MODE_RELATIVE;
		offer_item(FUNC_REPORT, '0, '0, 32'sd1005);
		offer_item(FUNC_REPORT, '0, '0, MERIT_MIN);

		// No backtracks at all: the first failing report finishes the search.
		program_regs(MODE_RELATIVE, 24'd1, 16'd1, 16'd1, 8'd0);
		offer_item(FUNC_START, 32'sh4000_0000, $urandom, '0);
		offer_item(FUNC_REPORT, '0, '0, MERIT_MAX);

		// Random part, one configuration per phase, extremes included. Every third
		// phase runs without idling and the last one has none at all.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_regs(MODE_RELATIVE, 24'd65536, 16'd32768, 16'd6554, 8'd30);
				1: program_regs(MODE_DIRECTIONAL, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd255);
				2: program_regs(MODE_RELATIVE, 24'd1, 16'd1, 16'd1, 8'd0);
				3: program_regs(MODE_DIRECTIONAL, $urandom, $urandom, $urandom,
					$urandom_range(0, 12));
				4: program_regs(MODE_RELATIVE, 24'h00_8000, 16'hC000, 16'hFFFF, 8'd255);
				5: program_regs(MODE_DIRECTIONAL, 24'h02_0000, 16'd40000, 16'd1, 8'd5);
				6: program_regs(MODE_RELATIVE, $urandom, $urandom, $urandom,
					$urandom_range(0, 12));
				default: program_regs(MODE_DIRECTIONAL, 24'd65536, 16'd32768, 16'd6554, 8'd8);
			endcase
			if (phase == PHASES - 1 || phase % 3 == 2) begin
				tx_odds = 0;
				rx_odds = 0;
			end else begin
				tx_odds = $urandom_range(10, 40);
				rx_odds = $urandom_range(5, 25);
			end
			if (phase == 1)
				exhaust_search();
			goal = items_sent + ITEMS_PER_PHASE;
			while (items_sent < goal) begin
				// Early in the first phase the receiver holds off for a long stretch
				// while items keep coming, so the block fills and stalls its input.
				if (phase == 0 && !pressed && items_sent + ITEMS_PER_PHASE - goal >= 40) begin
					hold_off = 1'b1;
					pressed  = 1'b1;
				end
				if ($urandom_range(0, 99) < 85)
					random_search();
				else
					stray_item();
			end
		end

		settle();
		if (fail_count == 0)
			$display("armijo_backtracking_search_test OK");
		else
			$display("armijo_backtracking_search_test NOT OK");
		$finish;
	end

endmodule
